// File: hw/rtl/hsvd_pkg.sv
// ============================================================================
// hsvd_pkg: shared types and constants for the HSV to RGB converter
// Payload structs, the perceptual dim curve table and pipeline sizing.
// ============================================================================
`default_nettype none

package hsvd_pkg;

    typedef logic [7:0] t_byte;

    // One input transaction: hue, saturation, value.
    typedef struct packed {
        t_byte hue;
        t_byte saturation;
        t_byte brightness;
    } t_hsv;

    // One result transaction.
    typedef struct packed {
        t_byte red;
        t_byte green;
        t_byte blue;
    } t_rgb;

    // Pipeline depth from accept to result strobe.
    localparam int unsigned PIPE_DEPTH = 4;

    // Exponential dim curve, index 0..255.
    localparam t_byte DIM_CURVE [0:255] = '{
          8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
          8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
          8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
          8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
          8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
          8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,
          8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
          8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,
          8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,
         8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
         8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,
         8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,
         8'd15,  8'd15,  8'd16,  8'd16,  8'd16,  8'd16,  8'd17,  8'd17,
         8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,  8'd20,
         8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
         8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,
         8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,
         8'd31,  8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,
         8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd40,
         8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
         8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
         8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
         8'd63,  8'd64,  8'd65,  8'd66,  8'd68,  8'd69,  8'd70,  8'd71,
         8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd81,  8'd82,
         8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
         8'd96,  8'd98,  8'd99, 8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
        8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
        8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
        8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
        8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
        8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
        8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
    };

endpackage

`default_nettype wire

// File: hw/rtl/hsv_to_rgb_dim_curve.sv
// ============================================================================
// hsv_to_rgb_dim_curve: 8-bit HSV to RGB converter with perceptual dim curve
// Pipelined pixel converter with an APB control register.
// ============================================================================
// Usage:
//   Input channel: drive i_hsv and pulse start. A transaction is taken at
//   every rising edge with start high and busy low. busy is tied low, so a
//   new pixel can be taken every clock.
//   Result channel: o_rgb is valid for exactly one cycle, flagged by
//   o_result_valid. The receiver has no backpressure and must take it then.
//   The four register stages are curve lookup, V*(255-S) and V*S, the
//   16x8 ramp product and sector select. Throughput: 1 pixel per clock.
//   Results leave in input order.
//   Control: register 0 (byte address 0), bit 0 = dim_curve_enable. When set,
//   S becomes 255-curve[255-S] and V becomes curve[V] before conversion.
//   Write it only while no pixel is in flight. Addresses 1 to 3 alias
//   register 0; addresses 4 to 7 read as zero and ignore writes.
//   Reset (synchronous, active low): pipeline valids clear, so no stray
//   result strobe appears; dim_curve_enable returns to 1.
// ============================================================================
`default_nettype none

module hsv_to_rgb_dim_curve (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // pixel in
    input  wire logic           start,
    output logic                busy,
    input  wire hsvd_pkg::t_hsv i_hsv,
    // pixel out
    output logic                o_result_valid,
    output hsvd_pkg::t_rgb      o_rgb,
    // APB control
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import hsvd_pkg::*;

    // Register index lives in paddr[2]; the low two bits are byte lanes.
    localparam logic REG_DIM_CURVE_EN = 1'b0;

    logic reg_idx;
    logic wr_en;
    logic r_dim_en, n_dim_en;
    logic accept;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        n_dim_en = r_dim_en;
        if (wr_en && reg_idx == REG_DIM_CURVE_EN) begin
            n_dim_en = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_en <= 1'b1;
        end else begin
            r_dim_en <= n_dim_en;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_DIM_CURVE_EN) begin
            prdata[0] = r_dim_en;
        end
    end

    // Fully pipelined: never refuses a transaction.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    hsvd_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_dim_en (r_dim_en),
        .i_hsv    (i_hsv),
        .o_valid  (o_result_valid),
        .o_rgb    (o_rgb)
    );

endmodule

`default_nettype wire

// File: hw/rtl/hsvd_datapath.sv
// ============================================================================
// hsvd_datapath: four-stage HSV to RGB pipeline
// Curve shaping, products, ramp product, then sector select into the output.
// ============================================================================
`default_nettype none

module hsvd_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_dim_en,
    input  wire hsvd_pkg::t_hsv i_hsv,
    output logic               o_valid,
    output hsvd_pkg::t_rgb     o_rgb
);
    import hsvd_pkg::*;

    // Hue sectors, each 60 degrees.
    localparam logic [2:0] SEC_RED     = 3'd0;
    localparam logic [2:0] SEC_YELLOW  = 3'd1;
    localparam logic [2:0] SEC_GREEN   = 3'd2;
    localparam logic [2:0] SEC_CYAN    = 3'd3;
    localparam logic [2:0] SEC_BLUE    = 3'd4;
    localparam logic [2:0] SEC_MAGENTA = 3'd5;

    // ---- stage 1: curve shaping, hue split
    logic        n_vld1;
    logic [2:0]  n_sec1;
    t_byte       n_t1, n_sat1, n_val1;
    logic [10:0] hue6;

    logic        r_vld1;
    logic [2:0]  r_sec1;
    t_byte       r_t1, r_sat1, r_val1;

    always_comb begin
        hue6   = {1'b0, i_hsv.hue, 2'b00} + {2'b00, i_hsv.hue, 1'b0};
        n_vld1 = i_valid;
        n_sec1 = hue6[10:8];
        n_t1   = hue6[7:0];
        if (i_dim_en) begin
            n_sat1 = 8'hff - DIM_CURVE[8'hff - i_hsv.saturation];
            n_val1 = DIM_CURVE[i_hsv.brightness];
        end else begin
            n_sat1 = i_hsv.saturation;
            n_val1 = i_hsv.brightness;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= n_vld1;
        end
        r_sec1 <= n_sec1;
        r_t1   <= n_t1;
        r_sat1 <= n_sat1;
        r_val1 <= n_val1;
    end

    // ---- stage 2: V*(255-S) and V*S
    logic [15:0] prod_low, n_vs2;
    logic        r_vld2;
    logic [2:0]  r_sec2;
    t_byte       r_t2, r_val2, r_lower2;
    logic [15:0] r_vs2;
    t_byte       sat_inv;

    always_comb begin
        sat_inv  = 8'hff - r_sat1;
        prod_low = {8'h00, r_val1} * {8'h00, sat_inv};
        n_vs2    = {8'h00, r_val1} * {8'h00, r_sat1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        r_sec2   <= r_sec1;
        r_t2     <= r_t1;
        r_val2   <= r_val1;
        r_lower2 <= prod_low[15:8];
        r_vs2    <= n_vs2;
    end

    // ---- stage 3: ramp = V*S*t >> 16
    logic [23:0] prod_ramp;
    logic        r_vld3;
    logic [2:0]  r_sec3;
    t_byte       r_val3, r_lower3, r_ramp3;

    assign prod_ramp = {8'h00, r_vs2} * {16'h0000, r_t2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= r_vld2;
        end
        r_sec3   <= r_sec2;
        r_val3   <= r_val2;
        r_lower3 <= r_lower2;
        r_ramp3  <= prod_ramp[23:16];
    end

    // ---- stage 4: sector select
    t_byte up, down;
    t_rgb  n_rgb;
    logic  r_vld4;
    t_rgb  r_rgb4;

    always_comb begin
        up   = r_lower3 + r_ramp3;   // never exceeds V
        down = r_val3 - r_ramp3;
        case (r_sec3)
            SEC_RED:     n_rgb = '{red: r_val3,   green: up,       blue: r_lower3};
            SEC_YELLOW:  n_rgb = '{red: down,     green: r_val3,   blue: r_lower3};
            SEC_GREEN:   n_rgb = '{red: r_lower3, green: r_val3,   blue: up};
            SEC_CYAN:    n_rgb = '{red: r_lower3, green: down,     blue: r_val3};
            SEC_BLUE:    n_rgb = '{red: up,       green: r_lower3, blue: r_val3};
            SEC_MAGENTA: n_rgb = '{red: r_val3,   green: r_lower3, blue: down};
            default:     n_rgb = '{red: r_val3,   green: r_lower3, blue: down};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else begin
            r_vld4 <= r_vld3;
        end
        r_rgb4 <= n_rgb;
    end

    assign o_valid = r_vld4;
    assign o_rgb   = r_rgb4;

    // ---- assertions
    a_vld_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 == ($past(r_vld1) && $past(i_rst_n)))
        else $error("stage 2 valid lost or invented");

    a_vld_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 == ($past(r_vld3) && $past(i_rst_n)))
        else $error("output strobe does not follow stage 3");

    a_ramp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld3 |-> (({1'b0, r_lower3} + {1'b0, r_ramp3}) <= {1'b0, r_val3}))
        else $error("lower plus ramp exceeds value");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> (r_sec1 <= SEC_MAGENTA))
        else $error("hue sector out of range");

endmodule

`default_nettype wire
